/* hw/rtl/spt_pkg.sv */
package spt_pkg;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned EXP_W = 16;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DEG_W = 17;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic signed [DEG_W-1:0] DEG_EMPTY = -17'sd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_ACCUM  = 3'd1,
    REQ_CHANGE = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic coef_rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic res_busy;
  } sts_t;

endpackage

/* hw/rtl/spt_req_if.sv */
interface spt_req_if;
  logic                                valid;
  logic                                ready;
  logic [spt_pkg::REQ_W-1:0]           req_type;
  logic [spt_pkg::EXP_W-1:0]           exponent;
  logic signed [spt_pkg::COEF_W-1:0]   coefficient;

  modport source (output valid, output req_type, output exponent, output coefficient,
                  input ready);
  modport sink (input valid, input req_type, input exponent, input coefficient,
                output ready);
endinterface

/* hw/rtl/spt_rsp_if.sv */
interface spt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [spt_pkg::COEF_W-1:0]   coefficient_out;
  logic signed [spt_pkg::DEG_W-1:0]    degree;
  logic [spt_pkg::CNT_OUT_W-1:0]       term_count;
  logic                                table_full;

  modport source (output valid, output ok, output coefficient_out, output degree,
                  output term_count, output table_full, input ready);
  modport sink (input valid, input ok, input coefficient_out, input degree,
                input term_count, input table_full, output ready);
endinterface

/* hw/rtl/spt_ctrl.sv */
module spt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spt_pkg::sts_t sts,
  output spt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_COEF = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef_rd = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.res_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/spt_dp.sv */
module spt_dp #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spt_pkg::cmd_t                       cmd,
  output spt_pkg::sts_t                       sts,
  input  logic [spt_pkg::REQ_W-1:0]           req_type,
  input  logic [spt_pkg::EXP_W-1:0]           exponent,
  input  logic signed [spt_pkg::COEF_W-1:0]   coefficient,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                ok,
  output logic signed [spt_pkg::COEF_W-1:0]   coefficient_out,
  output logic signed [spt_pkg::DEG_W-1:0]    degree,
  output logic [spt_pkg::CNT_OUT_W-1:0]       term_count,
  output logic                                table_full
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

  logic [spt_pkg::EXP_W-1:0]         exp_mem [SLOTS];
  logic [spt_pkg::COEF_W-1:0]        coef_mem [SLOTS];

  spt_pkg::req_t                     req_q;
  logic [spt_pkg::EXP_W-1:0]         key_q;
  logic [spt_pkg::COEF_W-1:0]        coef_q;

  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  logic signed [spt_pkg::DEG_W-1:0]  highest;
  logic signed [spt_pkg::DEG_W-1:0]  highest_next;

  logic [CW-1:0]                     ptr;
  logic                              rd_v;
  logic [AW-1:0]                     rd_idx;
  logic [spt_pkg::EXP_W-1:0]         exp_rd;
  logic                              hit;
  logic [AW-1:0]                     hit_idx;
  logic [spt_pkg::COEF_W-1:0]        coef_rd;

  logic                              found_now;
  logic                              step_rd;
  logic                              full;
  logic                              place;
  logic                              coef_we;
  logic [AW-1:0]                     coef_wa;
  logic [spt_pkg::COEF_W-1:0]        coef_wd;
  logic [spt_pkg::COEF_W-1:0]        sum;
  logic                              res_ok;
  logic [spt_pkg::COEF_W-1:0]        res_coef;
  logic                              res_full;

  assign found_now = rd_v && (exp_rd == key_q);
  assign step_rd   = cmd.scan && (ptr < count) && !found_now;
  assign full      = (count == SLOTS_CNT);
  assign sum       = coef_rd + coef_q;

  assign sts.scan_done = (req_q == spt_pkg::REQ_CLEAR) || found_now
                         || ((ptr == count) && !rd_v);
  assign sts.res_busy  = out_valid && !out_ready;

  always_comb begin
    place        = 1'b0;
    coef_we      = 1'b0;
    coef_wd      = coef_q;
    res_ok       = 1'b0;
    res_coef     = '0;
    res_full     = 1'b0;
    count_next   = count;
    highest_next = highest;
    case (req_q) inside
      spt_pkg::REQ_INSERT, spt_pkg::REQ_ACCUM: begin
        if (hit) begin
          if (req_q == spt_pkg::REQ_ACCUM) begin
            coef_we  = 1'b1;
            coef_wd  = sum;
            res_ok   = 1'b1;
            res_coef = sum;
          end else begin
            res_coef = coef_rd;
          end
        end else if (!full) begin
          place    = 1'b1;
          coef_we  = 1'b1;
          res_ok   = 1'b1;
          res_coef = coef_q;
        end else begin
          res_full = 1'b1;
        end
      end
      spt_pkg::REQ_CHANGE: begin
        if (hit) begin
          coef_we  = 1'b1;
          res_ok   = 1'b1;
          res_coef = coef_q;
        end
      end
      spt_pkg::REQ_LOOKUP: begin
        if (hit) begin
          res_ok   = 1'b1;
          res_coef = coef_rd;
        end
      end
      spt_pkg::REQ_CLEAR: begin
        res_ok       = 1'b1;
        count_next   = '0;
        highest_next = spt_pkg::DEG_EMPTY;
      end
      default: begin
        if (hit) begin
          res_coef = coef_rd;
        end
      end
    endcase
    if (place) begin
      count_next = count + 1'b1;
      if ($signed({1'b0, key_q}) > highest) begin
        highest_next = $signed({1'b0, key_q});
      end
    end
  end

  assign coef_wa = hit ? hit_idx : count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      highest   <= spt_pkg::DEG_EMPTY;
      ptr       <= '0;
      rd_v      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr  <= '0;
        rd_v <= 1'b0;
        hit  <= 1'b0;
      end else if (cmd.scan) begin
        rd_v <= step_rd;
        if (step_rd) begin
          ptr <= ptr + 1'b1;
        end
        if (found_now) begin
          hit <= 1'b1;
        end
      end
      if (cmd.exec) begin
        count     <= count_next;
        highest   <= highest_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= spt_pkg::req_t'(req_type);
      key_q  <= exponent;
      coef_q <= coefficient;
    end
    if (step_rd) begin
      exp_rd <= exp_mem[ptr[AW-1:0]];
      rd_idx <= ptr[AW-1:0];
    end
    if (cmd.scan && found_now) begin
      hit_idx <= rd_idx;
    end
    if (cmd.coef_rd) begin
      coef_rd <= coef_mem[hit_idx];
    end
    if (cmd.exec && place) begin
      exp_mem[count[AW-1:0]] <= key_q;
    end
    if (cmd.exec && coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    if (cmd.exec) begin
      ok              <= res_ok;
      coefficient_out <= res_coef;
      degree          <= highest_next;
      term_count      <= spt_pkg::CNT_OUT_W'(count_next);
      table_full      <= res_full;
    end
  end

endmodule

/* hw/rtl/sparse_polynomial_term_table.sv */
// Sparse polynomial term table: up to SLOTS terms, each an exponent key with a
// signed 32-bit coefficient. Requests arrive on the req channel (insert,
// accumulate, change coefficient, lookup, clear) and each one produces exactly
// one transaction on the rsp channel carrying ok, the coefficient, the degree,
// the term count and the table-full flag.
// Terms fill the slots in order, so the live terms always sit below the term
// count. A request scans the exponent memory one slot per cycle until it finds
// the key or reaches the term count, then reads the coefficient memory, then
// updates the table and loads the result register. A clear request, or one
// on an empty table, ends its scan at once. The next request is accepted as
// the result becomes valid; the exponent scan, which grows with the terms
// held, is what sets the time a request takes.
// A synchronous reset empties the table (degree -1, count 0) and drops any
// pending result; no clearing pass is needed. When the receiver stalls, the
// result stays in its register and the block may accept and scan the next
// request, holding it until the register frees up.
module sparse_polynomial_term_table #(
  parameter int unsigned SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  spt_req_if.sink   req,
  spt_rsp_if.source rsp
);

  spt_pkg::cmd_t cmd;
  spt_pkg::sts_t sts;
  logic          in_ready;

  assign req.ready = in_ready;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req.req_type),
    .exponent        (req.exponent),
    .coefficient     (req.coefficient),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .ok              (rsp.ok),
    .coefficient_out (rsp.coefficient_out),
    .degree          (rsp.degree),
    .term_count      (rsp.term_count),
    .table_full      (rsp.table_full)
  );

endmodule

/* hw/rtl/spt_checker.sv */
module spt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                ok,
  input logic signed [spt_pkg::COEF_W-1:0]   coefficient_out,
  input logic signed [spt_pkg::DEG_W-1:0]    degree,
  input logic [spt_pkg::CNT_OUT_W-1:0]       term_count,
  input logic                                table_full
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is being scanned");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok)
      && $stable(coefficient_out) && $stable(degree) && $stable(term_count)
      && $stable(table_full)))
    else $error("stalled result changed");

  a_full_not_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (!ok && coefficient_out == '0))
    else $error("refused term reported as taking effect");

  a_empty_degree: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degree == spt_pkg::DEG_EMPTY) |-> (term_count == '0))
    else $error("empty degree with terms held");

endmodule

bind sparse_polynomial_term_table spt_checker u_spt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .ok              (rsp.ok),
  .coefficient_out (rsp.coefficient_out),
  .degree          (rsp.degree),
  .term_count      (rsp.term_count),
  .table_full      (rsp.table_full)
);

/* tb/term_table_checker.sv */
module term_table_checker #(
  parameter int unsigned SLOTS = 64
) (
  input  logic clk,
  input  logic rst,
  spt_req_if   req,
  spt_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [DEG_W-1:0]  degree;
    logic [CNT_OUT_W-1:0]     term_count;
    logic                     table_full;
  } term_result_t;

  logic                     slot_used [SLOTS];
  logic [EXP_W-1:0]         slot_key  [SLOTS];
  logic signed [COEF_W-1:0] slot_coef [SLOTS];
  int unsigned              terms_held;
  logic signed [DEG_W-1:0]  top_exponent;
  term_result_t             expected_results [$];
  int                       error_count = 0;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int find_term(input logic [EXP_W-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit place_term(input logic [EXP_W-1:0] key,
                                    input logic signed [COEF_W-1:0] coef);
    int s;
    s = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) s = i;
    end
    if (s < 0) return 1'b0;
    slot_used[s] = 1'b1;
    slot_key[s] = key;
    slot_coef[s] = coef;
    terms_held++;
    if ($signed({1'b0, key}) > top_exponent) top_exponent = $signed({1'b0, key});
    return 1'b1;
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    terms_held = 0;
    top_exponent = DEG_EMPTY;
  endfunction

  function automatic term_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                 input logic [EXP_W-1:0] key,
                                                 input logic signed [COEF_W-1:0] coef);
    term_result_t r;
    int s;
    r = '0;
    s = find_term(key);
    case (kind)
      REQ_INSERT: begin
        if (s >= 0) begin
          r.coefficient = slot_coef[s];
        end else if (place_term(key, coef)) begin
          r.ok = 1'b1;
          r.coefficient = coef;
        end else begin
          r.table_full = 1'b1;
        end
      end
      REQ_ACCUM: begin
        if (s >= 0) begin
          slot_coef[s] = slot_coef[s] + coef;
          r.ok = 1'b1;
          r.coefficient = slot_coef[s];
        end else if (place_term(key, coef)) begin
          r.ok = 1'b1;
          r.coefficient = coef;
        end else begin
          r.table_full = 1'b1;
        end
      end
      REQ_CHANGE: begin
        if (s >= 0) begin
          slot_coef[s] = coef;
          r.ok = 1'b1;
          r.coefficient = coef;
        end
      end
      REQ_LOOKUP: begin
        if (s >= 0) begin
          r.ok = 1'b1;
          r.coefficient = slot_coef[s];
        end
      end
      REQ_CLEAR: begin
        empty_table();
        r.ok = 1'b1;
      end
      default: begin
        if (s >= 0) r.coefficient = slot_coef[s];
      end
    endcase
    r.degree = top_exponent;
    r.term_count = CNT_OUT_W'(terms_held);
    return r;
  endfunction

  task automatic report_mismatch(input string note, input term_result_t want,
                                 input term_result_t got);
    if (error_count < 10) begin
      $display("%0t rsp %s: expected ok=%0b coef=%0d degree=%0d count=%0d full=%0b",
               $realtime, note, want.ok, want.coefficient, want.degree,
               want.term_count, want.table_full);
      $display("%0t rsp %s:      got ok=%0b coef=%0d degree=%0d count=%0d full=%0b",
               $realtime, note, got.ok, got.coefficient, got.degree,
               got.term_count, got.table_full);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    term_result_t want;
    term_result_t got;
    if (rst) begin
      empty_table();
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_request(req.req_type, req.exponent,
                                                 req.coefficient));
      end
      if (rsp.valid && rsp.ready) begin
        got = '{ok: rsp.ok, coefficient: rsp.coefficient_out, degree: rsp.degree,
                term_count: rsp.term_count, table_full: rsp.table_full};
        if (expected_results.size() == 0) begin
          report_mismatch("transaction with nothing pending", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_mismatch("field mismatch", want, got);
        end
      end
    end
    mismatches <= error_count;
    outstanding <= expected_results.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AT = 100;
  localparam int DRAIN_CYCLES = SLOTS + 16;
  localparam int PHASE_ITEMS = 160;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

  localparam logic [EXP_W-1:0] EXP_MAX = 16'hffff;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fffffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  bit   holdoff_request = 1'b0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   directed_count;

  spt_req_if req_bus ();
  spt_rsp_if rsp_bus ();

  sparse_polynomial_term_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  term_table_checker #(
    .SLOTS(SLOTS)
  ) table_check (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_request = 1'b0;
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [EXP_W-1:0] key,
                              input logic signed [COEF_W-1:0] coef);
    case ((items_sent / PHASE_ITEMS) % 4)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
      default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.exponent <= key;
    req_bus.coefficient <= coef;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coefficient();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return COEF_MAX;
    if (roll < 16) return COEF_MIN;
    if (roll < 30) return $signed($urandom_range(20)) - 10;
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return REQ_INSERT;
    if (roll < 58) return REQ_ACCUM;
    if (roll < 70) return REQ_CHANGE;
    if (roll < 92) return REQ_LOOKUP;
    if (roll < 93) return REQ_CLEAR;
    case ($urandom_range(2))
      0: return REQ_SPARE_LO;
      1: return REQ_SPARE_MID;
      default: return REQ_SPARE_HI;
    endcase
  endfunction

  // Requests draw their exponents mostly from a small pool so that they hit
  // existing terms; a pool larger than the table drives it to full.
  task automatic run_episode(input int len, input int pool_size);
    logic [EXP_W-1:0] pool [$];
    logic [EXP_W-1:0] key;
    int roll;
    for (int i = 0; i < pool_size; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) pool.push_back('0);
      else if (roll < 10) pool.push_back(EXP_MAX);
      else pool.push_back(EXP_W'($urandom));
    end
    for (int i = 0; i < len; i++) begin
      if (items_sent == HOLDOFF_AT) holdoff_request = 1'b1;
      if ($urandom_range(9) == 0) key = EXP_W'($urandom);
      else key = pool[$urandom_range(pool.size() - 1)];
      send_request(pick_request(), key, pick_coefficient());
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_INSERT;
    req_bus.exponent <= '0;
    req_bus.coefficient <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_LOOKUP, '0, 32'sd9);
    send_request(REQ_INSERT, '0, COEF_MAX);
    send_request(REQ_INSERT, EXP_MAX, COEF_MIN);
    send_request(REQ_INSERT, '0, 32'sd5);
    send_request(REQ_ACCUM, '0, 32'sd1);
    send_request(REQ_ACCUM, EXP_MAX, COEF_MIN);
    send_request(REQ_LOOKUP, EXP_MAX, 32'sd0);
    send_request(REQ_LOOKUP, 16'h1234, 32'sd3);
    send_request(REQ_CHANGE, '0, -32'sd1);
    send_request(REQ_CHANGE, 16'd7, 32'sd42);
    send_request(REQ_ACCUM, 16'd300, -32'sd300);
    send_request(REQ_SPARE_LO, '0, 32'sd11);
    send_request(REQ_SPARE_MID, 16'h5555, 32'sd12);
    send_request(REQ_SPARE_HI, EXP_MAX, 32'sd13);
    send_request(REQ_CLEAR, 16'haaaa, 32'sh55555555);
    send_request(REQ_LOOKUP, '0, 32'sd0);
    send_request(REQ_ACCUM, 16'd1, 32'sd7);
    send_request(REQ_INSERT, 16'h8000, 32'sh12345678);
    send_request(REQ_CLEAR, '0, 32'sd0);
    directed_count = items_sent;

    run_episode(200, 96);
    while (items_sent < directed_count + ITEM_TARGET) begin
      if ($urandom_range(9) < 7) send_request(REQ_CLEAR, EXP_W'($urandom), $urandom);
      case ($urandom_range(2))
        0: run_episode($urandom_range(20, 180), $urandom_range(1, 8));
        1: run_episode($urandom_range(20, 180), $urandom_range(9, 40));
        default: run_episode($urandom_range(60, 180), $urandom_range(65, 120));
      endcase
    end
    req_bus.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
